// File: rtl/vt4x4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4x4_pkg
// Shared types and constants for the 4x4 vertex transform pipeline.
// ----------------------------------------------------------------------------
package vt4x4_pkg;

  // Fixed-point format: signed Q16.16
  localparam int unsigned CompW   = 32;
  localparam int unsigned ProdW   = 2 * CompW;
  localparam int unsigned FracW   = 16;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegW    = 64;
  localparam int unsigned AddrW   = 6;

  localparam logic [CompW-1:0] OneQ16 = 32'h0001_0000;

  // Input mode codes
  localparam logic [1:0] ModePoint = 2'd0;
  localparam logic [1:0] ModeFull  = 2'd1;
  localparam logic [1:0] ModeDir   = 2'd2;

  // Matrix registers after reset: identity (index 7 first)
  localparam logic [NumRegs-1:0][RegW-1:0] MatReset = {
    64'h0001_0000_0000_0000,  // row3_cols23
    64'h0000_0000_0000_0000,  // row3_cols01
    64'h0000_0000_0001_0000,  // row2_cols23
    64'h0000_0000_0000_0000,  // row2_cols01
    64'h0000_0000_0000_0000,  // row1_cols23
    64'h0001_0000_0000_0000,  // row1_cols01
    64'h0000_0000_0000_0000,  // row0_cols23
    64'h0000_0000_0001_0000   // row0_cols01
  };

  // Four Q16.16 components, element r pairs with matrix row r
  typedef logic [3:0][CompW-1:0] vec_t;

  // Load enables for the stages inside a dot-product lane
  typedef struct packed {
    logic mul;
    logic add;
    logic sat;
  } pipe_en_t;

endpackage

// File: rtl/vertex_transform_4x4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Row-vector times 4x4 matrix in signed Q16.16, matrix held in APB registers.
// ----------------------------------------------------------------------------
// Accepts one vector per clock while the output is not stalled and returns one
// transformed vector per input, passing through the input register, multiply,
// pair add and final add/saturate stages. Each stage has its
// own valid bit, so bubbles close up under backpressure and an input can be
// taken while a result waits. Mode 0 is a point (w = 1.0, translation row
// applied, w_out = 0), mode 2 a direction (w = 0, w_out = 0), modes 1 and 3 a
// full homogeneous transform. The matrix lives in eight 64-bit registers at
// byte addresses 8*i, each holding an even column entry in the low half and
// the odd column entry in the high half; reset value is the identity. Write
// the matrix only while no transfer is in flight.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input vector
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic signed [31:0] x_in_i,
  input  logic signed [31:0] y_in_i,
  input  logic signed [31:0] z_in_i,
  input  logic signed [31:0] w_in_i,
  // result vector
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic signed [31:0] z_out_o,
  output logic signed [31:0] w_out_o
);
  import vt4x4_pkg::*;

  logic [RegW-1:0]      mat_q [NumRegs];
  logic [2:0]           reg_idx;

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic                 full1_q, full2_q, full3_q, full4_q;
  logic                 en1, en2, en3, en4;
  logic                 full_d;
  logic [CompW-1:0]     w_d;
  vec_t                 vec_q;
  vec_t                 coef [4];
  logic [CompW-1:0]     res [4];
  pipe_en_t             lane_en;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign prdata  = mat_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        mat_q[i] <= MatReset[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      mat_q[reg_idx] <= pwdata;
    end
  end

  // Matrix column c, one entry per row
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (c[0]) begin
          coef[c][r] = mat_q[2 * r + c / 2][RegW-1:CompW];
        end else begin
          coef[c][r] = mat_q[2 * r + c / 2][CompW-1:0];
        end
      end
    end
  end

  // Stage enables: a stage moves when empty or when the next one moves
  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  assign lane_en.mul = en2;
  assign lane_en.add = en3;
  assign lane_en.sat = en4;

  // Mode decode: homogeneous w
  always_comb begin
    full_d = 1'b0;
    w_d    = '0;
    case (mode_i)
      ModePoint: w_d = OneQ16;
      ModeDir:   w_d = '0;
      ModeFull: begin
        full_d = 1'b1;
        w_d    = w_in_i;
      end
      default: begin
        // unused code behaves as a full transform
        full_d = 1'b1;
        w_d    = w_in_i;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Input register and mode flag travelling alongside
  always_ff @(posedge clk_i) begin
    if (en1) begin
      vec_q   <= {w_d, z_in_i, y_in_i, x_in_i};
      full1_q <= full_d;
    end
    if (en2) full2_q <= full1_q;
    if (en3) full3_q <= full2_q;
    if (en4) full4_q <= full3_q;
  end

  // One dot-product lane per result column
  for (genvar c = 0; c < 4; c++) begin : g_col
    vt4x4_dot4 u_dot (
      .clk_i  (clk_i),
      .en_i   (lane_en),
      .vec_i  (vec_q),
      .coef_i (coef[c]),
      .res_o  (res[c])
    );
  end

  // Result
  assign out_valid_o = v4_q;
  assign x_out_o     = res[0];
  assign y_out_o     = res[1];
  assign z_out_o     = res[2];
  assign w_out_o     = full4_q ? res[3] : '0;

endmodule

// File: rtl/vt4x4_dot4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4x4_dot4
// One result column: four 32x32 signed products, a two-level adder tree,
// then a floor shift by 16 and saturation to 32 bits. Three register stages.
// ----------------------------------------------------------------------------
module vt4x4_dot4 (
  input  logic                clk_i,
  input  vt4x4_pkg::pipe_en_t en_i,
  input  vt4x4_pkg::vec_t     vec_i,
  input  vt4x4_pkg::vec_t     coef_i,
  output logic [31:0]         res_o
);
  import vt4x4_pkg::*;

  localparam int unsigned PairW = ProdW + 1;
  localparam int unsigned SumW  = ProdW + 2;

  logic signed [ProdW-1:0] prod_q [4];
  logic signed [PairW-1:0] pair_q [2];
  logic signed [SumW-1:0]  sum_d;
  logic [CompW-1:0]        res_d;
  logic [CompW-1:0]        res_q;

  // Stage: full-width products
  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      for (int r = 0; r < 4; r++) begin
        prod_q[r] <= $signed(vec_i[r]) * $signed(coef_i[r]);
      end
    end
  end

  // Stage: pairwise sums
  always_ff @(posedge clk_i) begin
    if (en_i.add) begin
      pair_q[0] <= PairW'(prod_q[0]) + PairW'(prod_q[1]);
      pair_q[1] <= PairW'(prod_q[2]) + PairW'(prod_q[3]);
    end
  end

  // Final sum, floor shift, saturate
  always_comb begin
    sum_d = SumW'(pair_q[0]) + SumW'(pair_q[1]);
    // fits when all bits from the result sign upward agree
    if (&sum_d[SumW-1:FracW+CompW-1] || ~|sum_d[SumW-1:FracW+CompW-1]) begin
      res_d = sum_d[FracW+CompW-1:FracW];
    end else if (sum_d[SumW-1]) begin
      res_d = {1'b1, {(CompW-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(CompW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sat) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
